/* hw/rtl/typewriter_line_store_top_macros.svh */
// Assertion macros shared by the typewriter line store RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef TYPEWRITER_LINE_STORE_TOP_MACROS_SVH
`define TYPEWRITER_LINE_STORE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, checked at every rising clock edge outside of reset.
`define TLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
// Same-cycle implication, checked outside of reset.
`define TLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TLS_ASSERT(label, clk, rst, prop, msg)
`define TLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/tls_pkg.sv */
// Shared constants, codes and types of the typewriter line store.
// No dependencies; every other RTL file but the assertion macro header imports this package.
package tls_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int LINES_DEFAULT   = 20;

   localparam int CHAR_W   = 7;
   localparam int CODE_W   = 8;
   localparam int COL_W    = 7;
   localparam int LINE_W   = 5;
   localparam int TOTAL_W  = 32;
   localparam int ACT_W    = 2;
   localparam int DUR_W    = 9;

   localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
   localparam logic [CODE_W-1:0] CODE_TOP   = 8'd127;
   localparam logic [CODE_W-1:0] CODE_LOW_A = 8'd97;
   localparam logic [CODE_W-1:0] CODE_LOW_Z = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_BIT   = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;

   localparam logic [DUR_W-1:0] CHAR_TIME    = 9'd68;
   localparam logic [DUR_W-1:0] CR_BASE_TIME = 9'd204;
   localparam int               CR_SPAN_TIME = 272;

   // Carriage return timing: 272*n/COLUMNS by reciprocal multiplication.
   // The dividend is below 2^16 and COLUMNS below 2^7, so a shift of 23 is exact.
   localparam int DIVIDEND_W  = 16;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 23;

   localparam logic [ACT_W-1:0] HEAD_NONE  = 2'd0;
   localparam logic [ACT_W-1:0] HEAD_CR    = 2'd1;
   localparam logic [ACT_W-1:0] HEAD_PRINT = 2'd2;
   localparam logic [ACT_W-1:0] HEAD_MOVE  = 2'd3;

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CR    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PRINT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BS    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] ch;
      logic              glyph;
      logic              in_range;
      logic [LINE_W-1:0] rd_line;
      logic [COL_W-1:0]  rd_col;
   } cmd_type;

endpackage

/* hw/rtl/tls_channels.sv */
// Request and response channel interfaces of the typewriter line store.
// Depends on tls_pkg for the field widths.
interface tls_req_if import tls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [CODE_W-1:0] char_code;
   logic [LINE_W-1:0] read_line;
   logic [COL_W-1:0]  read_column;

   modport source(output valid, action, char_code, read_line, read_column, input ready);
   modport sink(input valid, action, char_code, read_line, read_column, output ready);
endinterface

interface tls_rsp_if import tls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  cell_char;
   logic [COL_W-1:0]   cur_column;
   logic [LINE_W-1:0]  cur_line_slot;
   logic [TOTAL_W-1:0] lines_printed;
   logic [ACT_W-1:0]   head_action;
   logic [COL_W-1:0]   head_position;
   logic [DUR_W-1:0]   duration_ms;
   logic               duration_set;
   logic               paper_changed;

   modport source(output valid, cell_char, cur_column, cur_line_slot, lines_printed,
                  head_action, head_position, duration_ms, duration_set, paper_changed,
                  input ready);
   modport sink(input valid, cell_char, cur_column, cur_line_slot, lines_printed,
                head_action, head_position, duration_ms, duration_set, paper_changed,
                output ready);
endinterface

/* hw/rtl/tls_front.sv */
// Front end: takes request items, classifies them and pushes them to the queue.
// Depends on tls_pkg and tls_req_if.
module tls_front import tls_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int LINES   = LINES_DEFAULT
) (
   tls_req_if.sink req_ch,
   input  logic    clearing,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic [CODE_W-1:0] code;

   assign code         = req_ch.char_code;
   assign req_ch.ready = !q_full && !clearing;
   assign q_push       = req_ch.valid && req_ch.ready;

   always_comb begin
      q_cmd.kind     = KIND_OTHER;
      q_cmd.ch       = code[CHAR_W-1:0];
      q_cmd.glyph    = (code > CODE_SPACE);
      q_cmd.rd_line  = req_ch.read_line;
      q_cmd.rd_col   = req_ch.read_column;
      q_cmd.in_range = ({1'b0, req_ch.read_line} < (LINE_W + 1)'(LINES))
                       && ({1'b0, req_ch.read_column} < (COL_W + 1)'(COLUMNS));
      if (code inside {[CODE_LOW_A:CODE_LOW_Z]}) begin
         q_cmd.ch = code[CHAR_W-1:0] & ~CASE_BIT;
      end
      if (req_ch.action) begin
         q_cmd.kind = KIND_READ;
      end else if (code == CODE_CR) begin
         q_cmd.kind = KIND_CR;
      end else if (code inside {[CODE_SPACE:CODE_TOP]}) begin
         q_cmd.kind = KIND_PRINT;
      end else if (code == CODE_BS) begin
         q_cmd.kind = KIND_BS;
      end
   end

endmodule

/* hw/rtl/tls_queue.sv */
// Short command queue between the front and the back of the line store.
// Depends on tls_pkg for cmd_type and the queue depth.
module tls_queue import tls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/tls_back.sv */
// Back end: page memory, head state, line fill sequencer and result register.
// Depends on tls_pkg, tls_rsp_if and the assertion macro header.
`include "typewriter_line_store_top_macros.svh"

module tls_back import tls_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int LINES   = LINES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  cmd_type   q_cmd,
   output logic      q_pop,
   output logic      clearing,
   tls_rsp_if.source rsp_ch
);

   localparam int DEPTH  = LINES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'(((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_FILL  = 2'd2;
   localparam logic [1:0] B_READ  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [ADDR_W-1:0]             clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]             fill_addr_ff, fill_addr_in;
   logic [COL_W-1:0]              fill_cnt_ff, fill_cnt_in;
   logic                          dur_pending_ff, dur_pending_in;
   logic [DIVIDEND_W-1:0]         dividend_ff, dividend_in;
   logic [DIVIDEND_W+RECIP_W-1:0] prod_ff;

   logic [COL_W-1:0]   column_ff, column_in;
   logic [LINE_W-1:0]  slot_ff, slot_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [COL_W-1:0]   hcol_ff, hcol_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic               rsp_dset_ff, rsp_dset_in;
   logic               rsp_changed_ff, rsp_changed_in;

   logic [CHAR_W-1:0]  page_mem_ff [DEPTH];
   logic [CHAR_W-1:0]  rd_data_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [CHAR_W-1:0]  mem_wdata;

   logic               out_free;
   logic [LINE_W:0]    slot_inc;
   logic [LINE_W-1:0]  slot_next;
   logic [COL_W-1:0]   col_inc;
   logic [TOTAL_W-1:0] total_base;
   logic [COL_W-1:0]   cr_n;
   logic [ADDR_W-1:0]  row_base, next_row_base, rd_addr;
   logic [DUR_W-1:0]   quotient;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop         = (state_ff == B_IDLE) && q_valid && out_free;
   assign clearing      = (state_ff == B_CLEAR);
   assign slot_inc      = {1'b0, slot_ff} + 1'b1;
   assign slot_next     = (slot_inc == (LINE_W + 1)'(LINES)) ? '0 : slot_inc[LINE_W-1:0];
   assign col_inc       = column_ff + 1'b1;
   assign total_base    = (total_ff == '0) ? TOTAL_W'(1) : total_ff;
   assign cr_n          = (column_ff == '0) ? COL_W'(COLUMNS) : column_ff;
   assign row_base      = ADDR_W'(slot_ff * COLUMNS);
   assign next_row_base = ADDR_W'(slot_next * COLUMNS);
   assign rd_addr       = ADDR_W'(q_cmd.rd_line * COLUMNS + q_cmd.rd_col);
   assign quotient      = prod_ff[RECIP_SHIFT +: DUR_W];

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      fill_addr_in   = fill_addr_ff;
      fill_cnt_in    = fill_cnt_ff;
      dur_pending_in = dur_pending_ff;
      dividend_in    = dividend_ff;
      column_in      = column_ff;
      slot_in        = slot_ff;
      total_in       = total_ff;
      act_in         = act_ff;
      hcol_in        = hcol_ff;
      dur_in         = dur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_cell_in    = rsp_cell_ff;
      rsp_dset_in    = rsp_dset_ff;
      rsp_changed_in = rsp_changed_ff;
      mem_we         = 1'b0;
      mem_waddr      = fill_addr_ff;
      mem_wdata      = CHAR_SPACE;
      mem_re         = 1'b0;
      mem_raddr      = rd_addr;

      case (state_ff)
         B_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_pop) begin
               rsp_cell_in    = '0;
               rsp_dset_in    = 1'b0;
               rsp_changed_in = 1'b0;
               case (q_cmd.kind)
                  KIND_READ: begin
                     if (q_cmd.in_range) begin
                        mem_re   = 1'b1;
                        state_in = B_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_CR: begin
                     total_in       = total_base + 1'b1;
                     act_in         = HEAD_CR;
                     hcol_in        = column_ff;
                     column_in      = '0;
                     slot_in        = slot_next;
                     dividend_in    = DIVIDEND_W'(cr_n) * DIVIDEND_W'(CR_SPAN_TIME);
                     dur_pending_in = 1'b1;
                     fill_addr_in   = next_row_base;
                     fill_cnt_in    = COL_W'(COLUMNS - 1);
                     state_in       = B_FILL;
                  end
                  KIND_PRINT: begin
                     mem_we    = 1'b1;
                     mem_waddr = row_base + ADDR_W'(column_ff);
                     mem_wdata = q_cmd.ch;
                     dur_in    = CHAR_TIME;
                     if (q_cmd.glyph) begin
                        act_in  = HEAD_PRINT;
                        hcol_in = column_ff;
                     end else begin
                        act_in  = HEAD_MOVE;
                     end
                     if (col_inc == COL_W'(COLUMNS)) begin
                        // Line full: implied return, duration stays at one character.
                        total_in       = total_base + 1'b1;
                        act_in         = HEAD_CR;
                        hcol_in        = col_inc;
                        column_in      = '0;
                        slot_in        = slot_next;
                        dur_pending_in = 1'b0;
                        fill_addr_in   = next_row_base;
                        fill_cnt_in    = COL_W'(COLUMNS - 1);
                        state_in       = B_FILL;
                     end else begin
                        total_in       = total_base;
                        column_in      = col_inc;
                        rsp_valid_in   = 1'b1;
                        rsp_dset_in    = 1'b1;
                        rsp_changed_in = 1'b1;
                     end
                  end
                  KIND_BS: begin
                     total_in = total_base;
                     dur_in   = CHAR_TIME;
                     if (column_ff != '0) begin
                        column_in = column_ff - 1'b1;
                        act_in    = HEAD_MOVE;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_dset_in  = 1'b1;
                  end
                  default: begin
                     total_in     = total_base;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         B_FILL: begin
            mem_we       = 1'b1;
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_cnt_in  = fill_cnt_ff - 1'b1;
            if (fill_cnt_ff == '0) begin
               state_in       = B_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = '0;
               rsp_dset_in    = 1'b1;
               rsp_changed_in = 1'b1;
               if (dur_pending_ff) begin
                  dur_in = CR_BASE_TIME + quotient;
               end
            end
         end
         B_READ: begin
            state_in       = B_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_cell_in    = rd_data_ff;
            rsp_dset_in    = 1'b0;
            rsp_changed_in = 1'b0;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_CLEAR;
         clr_addr_ff    <= '0;
         column_ff      <= '0;
         slot_ff        <= '0;
         total_ff       <= '0;
         act_ff         <= HEAD_NONE;
         hcol_ff        <= '0;
         dur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         dur_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         column_ff      <= column_in;
         slot_ff        <= slot_in;
         total_ff       <= total_in;
         act_ff         <= act_in;
         hcol_ff        <= hcol_in;
         dur_ff         <= dur_in;
         rsp_valid_ff   <= rsp_valid_in;
         dur_pending_ff <= dur_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_addr_ff   <= fill_addr_in;
      fill_cnt_ff    <= fill_cnt_in;
      dividend_ff    <= dividend_in;
      prod_ff        <= dividend_ff * RECIP_M;
      rsp_cell_ff    <= rsp_cell_in;
      rsp_dset_ff    <= rsp_dset_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= page_mem_ff[mem_raddr];
      end
   end

   // The result fields show the head state, which only moves when the next item is taken.
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cell_char     = rsp_cell_ff;
   assign rsp_ch.cur_column    = column_ff;
   assign rsp_ch.cur_line_slot = slot_ff;
   assign rsp_ch.lines_printed = total_ff;
   assign rsp_ch.head_action   = act_ff;
   assign rsp_ch.head_position = hcol_ff;
   assign rsp_ch.duration_ms   = dur_ff;
   assign rsp_ch.duration_set  = rsp_dset_ff;
   assign rsp_ch.paper_changed = rsp_changed_ff;

   `TLS_ASSERT(a_column_range, clock, reset, column_ff < COL_W'(COLUMNS), "column out of range")
   `TLS_ASSERT(a_slot_range, clock, reset, {1'b0, slot_ff} < (LINE_W + 1)'(LINES), "slot out of range")
   `TLS_ASSERT_IMPL(a_fill_count, clock, reset, state_ff == B_FILL, fill_cnt_ff < COL_W'(COLUMNS), "fill count past the line")
   `TLS_ASSERT_IMPL(a_result_when_idle, clock, reset, rsp_valid_ff, state_ff == B_IDLE, "result shown while busy")

endmodule

/* hw/rtl/typewriter_line_store_top.sv */
// Top level of the typewriter line store: front, command queue and back.
// Depends on tls_pkg, tls_channels, tls_front, tls_queue and tls_back.
//
// Usage: req_ch carries one item per handshake: a put of one character
// (action 0) or a read of one page cell (action 1). rsp_ch returns exactly
// one result item per request item, in order, showing the head state after it.
// A put of a character that does not end the line, a backspace, another
// code or an out-of-range read gets its result registered straight from the
// idle state; an in-range read first passes the registered page memory read
// (state B_READ); a carriage return, explicit or implied, first passes the
// B_FILL state, which fills the next line with spaces one cell a cycle
// through the single memory write port. Items are worked one at a time; a
// queue of two items sits in front of the worker, so the sustained rate is
// set by the line fill sequencer. After reset a clearing pass writes zero to
// all LINES * COLUMNS cells, one per cycle; req_ch.ready stays low during
// that pass. When rsp_ch.ready is low the result is held unchanged and the
// queue keeps accepting items until it is full.
module typewriter_line_store_top import tls_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int LINES   = LINES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tls_req_if.sink   req_ch,
   tls_rsp_if.source rsp_ch
);

   cmd_type push_cmd, pop_cmd;
   logic    q_push, q_full, q_pop, q_valid, clearing;

   tls_front #(
      .COLUMNS(COLUMNS),
      .LINES  (LINES)
   ) u_front (
      .req_ch  (req_ch),
      .clearing(clearing),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   tls_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_cmd  (pop_cmd)
   );

   tls_back #(
      .COLUMNS(COLUMNS),
      .LINES  (LINES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .clearing(clearing),
      .rsp_ch  (rsp_ch)
   );

endmodule

/* test/tb.sv */
// Self-checking bench for typewriter_line_store_top: random and directed key items.
// Uses tls_pkg and the tls_req_if / tls_rsp_if channel interfaces from the RTL.
module tb import tls_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = COLUMNS_DEFAULT;
   localparam int ROWS = LINES_DEFAULT;
   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;
   localparam int RANDOM_ITEMS = 1350;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic              action;
      logic [CODE_W-1:0] char_code;
      logic [LINE_W-1:0] read_line;
      logic [COL_W-1:0]  read_column;
   } key_item_t;

   typedef struct packed {
      logic [CHAR_W-1:0]  cell_char;
      logic [COL_W-1:0]   cur_column;
      logic [LINE_W-1:0]  cur_line_slot;
      logic [TOTAL_W-1:0] lines_printed;
      logic [ACT_W-1:0]   head_action;
      logic [COL_W-1:0]   head_position;
      logic [DUR_W-1:0]   duration_ms;
      logic               duration_set;
      logic               paper_changed;
   } head_report_t;

   logic clock = 1'b0;
   logic reset;

   tls_req_if req_ch();
   tls_rsp_if rsp_ch();

   typewriter_line_store_top #(.COLUMNS(COLS), .LINES(ROWS)) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   key_item_t    keystrokes[$];
   head_report_t pending_reports[$];
   key_item_t    on_wire;
   int           total_items;
   int           sent_count;
   int           send_gap;
   int           recv_gap;
   int           hold_left;
   bit           hold_done;
   int           mismatches;
   int           reports_checked;

   // Shadow of the page and head state.
   logic [CHAR_W-1:0]  page_img [ROWS][COLS];
   int                 line_slot;
   int                 column_pos;
   int                 head_col;
   logic [TOTAL_W-1:0] line_total;
   logic [ACT_W-1:0]   head_act;
   logic [DUR_W-1:0]   op_duration;
   int                 returns_seen;
   int                 full_line_wraps;
   int                 reads_seen;
   int                 backspaces_seen;

   function automatic void advance_line();
      int nxt;
      int n;
      nxt = (line_slot + 1) % ROWS;
      for (int i = 0; i < COLS; i++) page_img[nxt][i] = CHAR_SPACE;
      head_act = HEAD_CR;
      head_col = column_pos;
      column_pos = 0;
      line_slot = nxt;
      line_total = line_total + 1;
      returns_seen++;
      n = head_col;
      if (n < 1 || n > COLS) n = COLS;
      op_duration = DUR_W'(CR_BASE_TIME + (CR_SPAN_TIME * n) / COLS);
   endfunction

   function automatic head_report_t predict_head_report(key_item_t k);
      head_report_t r;
      logic [CHAR_W-1:0] ch;
      r = '0;
      if (k.action == ACT_READ) begin
         reads_seen++;
         if (k.read_line < ROWS && k.read_column < COLS)
            r.cell_char = page_img[k.read_line][k.read_column];
      end else begin
         if (line_total == 0) line_total = 1;
         if (k.char_code == CODE_CR) begin
            advance_line();
            r.duration_set = 1'b1;
            r.paper_changed = 1'b1;
         end else if (k.char_code >= CODE_SPACE && k.char_code <= CODE_TOP) begin
            ch = k.char_code[CHAR_W-1:0];
            if (k.char_code >= CODE_LOW_A && k.char_code <= CODE_LOW_Z) ch = ch & ~CASE_BIT;
            page_img[line_slot][column_pos % COLS] = ch;
            if (k.char_code > CODE_SPACE) begin
               head_act = HEAD_PRINT;
               head_col = column_pos;
            end else begin
               head_act = HEAD_MOVE;
            end
            column_pos++;
            if (column_pos >= COLS) begin
               advance_line();
               full_line_wraps++;
            end
            // Even after an implied return the reported time is one character.
            op_duration = CHAR_TIME;
            r.duration_set = 1'b1;
            r.paper_changed = 1'b1;
         end else if (k.char_code == CODE_BS) begin
            backspaces_seen++;
            if (column_pos != 0) begin
               column_pos--;
               head_act = HEAD_MOVE;
            end
            op_duration = CHAR_TIME;
            r.duration_set = 1'b1;
         end
      end
      r.cur_column    = column_pos[COL_W-1:0];
      r.cur_line_slot = line_slot[LINE_W-1:0];
      r.lines_printed = line_total;
      r.head_action   = head_act;
      r.head_position = head_col[COL_W-1:0];
      r.duration_ms   = op_duration;
      return r;
   endfunction

   task automatic put_key(input logic [CODE_W-1:0] code);
      key_item_t k;
      k.action = ACT_PUT;
      k.char_code = code;
      k.read_line = LINE_W'($urandom);
      k.read_column = COL_W'($urandom);
      keystrokes.push_back(k);
   endtask

   task automatic read_cell(input logic [LINE_W-1:0] l, input logic [COL_W-1:0] c);
      key_item_t k;
      k.action = ACT_READ;
      k.char_code = CODE_W'($urandom);
      k.read_line = l;
      k.read_column = c;
      keystrokes.push_back(k);
   endtask

   // Driver: present queued items, predict each one as it is accepted.
   always @(posedge clock) begin
      bit fired;
      bit gaps_on;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         fired = req_ch.valid && req_ch.ready;
         gaps_on = sent_count < total_items - QUIET_TAIL;
         if (fired) begin
            pending_reports.push_back(predict_head_report(on_wire));
            sent_count <= sent_count + 1;
         end
         if (fired || !req_ch.valid) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (keystrokes.size() > 0) begin
               on_wire = keystrokes.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= on_wire.action;
               req_ch.char_code   <= on_wire.char_code;
               req_ch.read_line   <= on_wire.read_line;
               req_ch.read_column <= on_wire.read_column;
               if (gaps_on && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off so that the block fills up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_count >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Monitor: compare each result item with the oldest prediction.
   always @(posedge clock) begin
      head_report_t got;
      head_report_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.cell_char     = rsp_ch.cell_char;
            got.cur_column    = rsp_ch.cur_column;
            got.cur_line_slot = rsp_ch.cur_line_slot;
            got.lines_printed = rsp_ch.lines_printed;
            got.head_action   = rsp_ch.head_action;
            got.head_position = rsp_ch.head_position;
            got.duration_ms   = rsp_ch.duration_ms;
            got.duration_set  = rsp_ch.duration_set;
            got.paper_changed = rsp_ch.paper_changed;
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result item with no prediction waiting", $realtime);
            end else begin
               want = pending_reports.pop_front();
               reports_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result %0d differs (cell col slot lines act pos dur set chg)",
                              $realtime, reports_checked);
                     $display("   expected %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                              want.cell_char, want.cur_column, want.cur_line_slot,
                              want.lines_printed, want.head_action, want.head_position,
                              want.duration_ms, want.duration_set, want.paper_changed);
                     $display("   actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                              got.cell_char, got.cur_column, got.cur_line_slot,
                              got.lines_printed, got.head_action, got.head_position,
                              got.duration_ms, got.duration_set, got.paper_changed);
                  end
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (sent_count < total_items - QUIET_TAIL && $urandom_range(0, 11) == 0)
               recv_gap = $urandom_range(1, 18);
         end
      end
   end

   initial begin
      int len;
      int pick;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_PUT;
      req_ch.char_code = '0;
      req_ch.read_line = '0;
      req_ch.read_column = '0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      total_items = 1 << 30;
      sent_count = 0;
      mismatches = 0;
      reports_checked = 0;
      line_slot = 0;
      column_pos = 0;
      head_col = 0;
      line_total = '0;
      head_act = HEAD_NONE;
      op_duration = '0;
      returns_seen = 0;
      full_line_wraps = 0;
      reads_seen = 0;
      backspaces_seen = 0;
      for (int l = 0; l < ROWS; l++)
         for (int c = 0; c < COLS; c++) page_img[l][c] = '0;

      // Directed opening: fresh page, code classes, case folding edges, page bounds.
      read_cell('0, '0);
      read_cell(5'd31, 7'd127);
      put_key(8'd0);                 // an ignored code still marks the first use
      put_key(CODE_BS);              // backspace at the left margin
      put_key(CODE_LOW_A);
      put_key(CODE_LOW_Z);
      put_key(CODE_LOW_A - 8'd1);
      put_key(CODE_LOW_Z + 8'd1);
      put_key(CODE_TOP);
      put_key(CODE_SPACE);
      put_key(8'd255);
      put_key(8'd128);
      put_key(CODE_SPACE - 8'd1);
      put_key(8'd9);
      put_key(CODE_BS);
      put_key(CODE_CR);
      put_key(CODE_CR);              // return from column zero takes the full time
      put_key(8'd77);
      read_cell('0, '0);
      read_cell('0, COL_W'(3));
      read_cell(LINE_W'(1), '0);
      read_cell(LINE_W'(2), '0);
      read_cell(LINE_W'(ROWS - 1), COL_W'(COLS - 1));
      read_cell(LINE_W'(ROWS), '0);
      read_cell('0, COL_W'(COLS));

      // Random part: mostly typed lines, some long enough to wrap, plus reads and noise.
      while (keystrokes.size() < RANDOM_ITEMS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(76, 90) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 6) put_key(CODE_BS);
               else if (pick < 9) put_key(($urandom_range(0, 1) == 0) ?
                                          CODE_W'($urandom_range(0, 31)) :
                                          CODE_W'($urandom_range(128, 255)));
               else if (pick < 14) read_cell(LINE_W'($urandom_range(0, ROWS - 1)),
                                             COL_W'($urandom_range(0, COLS - 1)));
               else if (pick < 50) put_key(CODE_W'($urandom_range(CODE_LOW_A, CODE_LOW_Z)));
               else if (pick < 60) put_key(CODE_SPACE);
               else put_key(CODE_W'($urandom_range(CODE_SPACE, CODE_TOP)));
            end
            if ($urandom_range(0, 99) < 85) put_key(CODE_CR);
         end else if (pick < 85) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 4) == 0) read_cell(LINE_W'($urandom), COL_W'($urandom));
               else read_cell(LINE_W'($urandom_range(0, ROWS - 1)),
                              COL_W'($urandom_range(0, COLS - 1)));
            end
         end else begin
            if ($urandom_range(0, 1) == 0) put_key(CODE_W'($urandom));
            else read_cell(LINE_W'($urandom), COL_W'($urandom));
         end
      end
      total_items = keystrokes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (keystrokes.size() != 0 || req_ch.valid) @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2 * COLS + 10) @(posedge clock);
      if (pending_reports.size() != 0) mismatches++;

      $display("Checked %0d results over %0d items: %0d reads, %0d backspaces,",
               reports_checked, total_items, reads_seen, backspaces_seen);
      $display("%0d line advances of which %0d came from a full line.",
               returns_seen, full_line_wraps);
      if (mismatches == 0) begin
         $display("[typewriter_line_store_top] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[typewriter_line_store_top] ERROR");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("Timed out with %0d results still expected", pending_reports.size());
      $display("[typewriter_line_store_top] ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tls_pkg.sv
hw/rtl/tls_channels.sv
hw/rtl/tls_front.sv
hw/rtl/tls_queue.sv
hw/rtl/tls_back.sv
hw/rtl/typewriter_line_store_top.sv
test/tb.sv
